// ===== rtl/ipdbf_pkg.sv =====
// Package with the shared widths, the palette table and the result record type.
package ipdbf_pkg;

	localparam int PIXEL_W = 8;
	localparam int BUS_W   = 8;
	localparam int LEN_W   = 6;

	localparam logic [LEN_W-1:0] COLUMN_BYTES_RESET = 6'd60;

	localparam logic [BUS_W-1:0] BUS_TABLE [16] = '{
		8'd0,  8'd9,  8'd18, 8'd27, 8'd33,  8'd40,  8'd51,  8'd58,
		8'd66, 8'd75, 8'd80, 8'd89, 8'd99, 8'd106, 8'd113, 8'd120
	};

	// One result on its way from the sequencer to the output register.
	typedef struct packed {
		logic [PIXEL_W-1:0] pair;
		logic               is_replay;
		logic               last_result;
		logic               partial_column;
	} res_t;

	function automatic logic [BUS_W-1:0] bus_value(input logic [3:0] idx);
		return BUS_TABLE[idx];
	endfunction

endpackage

// ===== rtl/ipdbf_if.sv =====
// Channel interfaces for the pixel input, the bus output and the configuration write.
interface ipdbf_in_if;
	logic                          valid;
	logic                          ready;
	logic [ipdbf_pkg::PIXEL_W-1:0] pixel_pair;
	logic                          end_of_buffer;

	modport source (output valid, output pixel_pair, output end_of_buffer, input ready);
	modport sink (input valid, input pixel_pair, input end_of_buffer, output ready);
endinterface

interface ipdbf_out_if;
	logic                        valid;
	logic                        ready;
	logic [ipdbf_pkg::BUS_W-1:0] bus_first;
	logic [ipdbf_pkg::BUS_W-1:0] bus_second;
	logic                        is_replay;
	logic                        last_result;
	logic                        partial_column;

	modport source (output valid, output bus_first, output bus_second, output is_replay,
		output last_result, output partial_column, input ready);
	modport sink (input valid, input bus_first, input bus_second, input is_replay,
		input last_result, input partial_column, output ready);
endinterface

interface ipdbf_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [ipdbf_pkg::LEN_W-1:0] column_bytes;

	modport source (output valid, output column_bytes, input ready);
	modport sink (input valid, input column_bytes, output ready);
endinterface

// ===== rtl/ipdbf_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module ipdbf_ram #(
	parameter int W = 8,
	parameter int DEPTH = 60,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem_q [DEPTH];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/ipdbf_seq.sv =====
// Sequencer that takes in pixel bytes, fills the column store and replays full columns.
module ipdbf_seq #(
	parameter int MAX_COLUMN_BYTES = 60,
	localparam int AW = (MAX_COLUMN_BYTES > 1) ? $clog2(MAX_COLUMN_BYTES) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ipdbf_pkg::LEN_W-1:0]   column_bytes,
	input  logic                          pix_valid,
	input  logic [ipdbf_pkg::PIXEL_W-1:0] pix_pair,
	input  logic                          pix_eob,
	output logic                          pix_ready,
	input  logic                          slot_free,
	output logic                          res_load,
	output ipdbf_pkg::res_t               res,
	output logic                          ram_we,
	output logic [AW-1:0]                 ram_waddr,
	output logic                          ram_re,
	output logic [AW-1:0]                 ram_raddr,
	input  logic [ipdbf_pkg::PIXEL_W-1:0] ram_rdata
);
	import ipdbf_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_RD   = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_COLUMN_BYTES);

	logic [1:0]       state_q;
	logic [LEN_W-1:0] fill_q;
	logic [LEN_W-1:0] cnt_q;
	logic [LEN_W-1:0] idx_q;

	logic [LEN_W-1:0] eff_len;
	logic [LEN_W-1:0] fill_inc;
	logic [LEN_W-1:0] idx_next;
	logic             has_room;
	logic             accept;
	logic             complete;
	logic             replay_last;

	always_comb begin
		if (column_bytes == '0) begin
			eff_len = LEN_W'(1);
		end else if (column_bytes > MAX_LEN) begin
			eff_len = MAX_LEN;
		end else begin
			eff_len = column_bytes;
		end
	end

	assign has_room    = fill_q < MAX_LEN;
	assign fill_inc    = has_room ? fill_q + LEN_W'(1) : fill_q;
	assign complete    = fill_inc >= eff_len;
	assign idx_next    = idx_q + LEN_W'(1);
	assign replay_last = idx_next == cnt_q;

	assign pix_ready = (state_q == ST_IDLE) && slot_free;
	assign accept    = pix_ready && pix_valid;

	assign ram_we    = accept && has_room;
	assign ram_waddr = fill_q[AW-1:0];

	always_comb begin
		res_load  = 1'b0;
		res       = '0;
		ram_re    = 1'b0;
		ram_raddr = idx_q[AW-1:0];
		case (state_q)
			ST_IDLE: begin
				res_load           = accept;
				res.pair           = pix_pair;
				res.last_result    = !complete;
				res.partial_column = !complete && pix_eob;
			end
			ST_RD: begin
				ram_re = 1'b1;
			end
			ST_EMIT: begin
				res_load        = slot_free;
				res.pair        = ram_rdata;
				res.is_replay   = 1'b1;
				res.last_result = replay_last;
				// Fetch the next stored byte as this one leaves.
				ram_re    = slot_free && !replay_last;
				ram_raddr = idx_next[AW-1:0];
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			cnt_q   <= '0;
			idx_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (complete) begin
							cnt_q   <= fill_inc;
							idx_q   <= '0;
							fill_q  <= '0;
							state_q <= ST_RD;
						end else if (pix_eob) begin
							fill_q <= '0;
						end else begin
							fill_q <= fill_inc;
						end
					end
				end
				ST_RD: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (slot_free) begin
						idx_q <= idx_next;
						if (replay_last) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/indexed_pixel_doubling_bus_feeder.sv =====
// Top level: configuration register, column store, sequencer and bus output register.
// A byte's direct result is on the bus in the cycle after the byte's transaction. A new byte
// is taken whenever the output register is free and no column is being replayed; a byte that
// completes a column of n bytes holds the input through a store read state, then n replay
// results at one result per cycle out of the registered store read, longer if the bus stalls.
// Reset: sequencer, fill count and output valid clear, column_bytes returns to 60; the
// column store is not cleared, since only entries of the current column are ever read.
module indexed_pixel_doubling_bus_feeder #(
	parameter int MAX_COLUMN_BYTES = 60
) (
	input logic           clk,
	input logic           arst_n,
	ipdbf_cfg_if.sink     cfg,
	ipdbf_in_if.sink      pix,
	ipdbf_out_if.source   bus
);
	import ipdbf_pkg::*;

	localparam int AW = (MAX_COLUMN_BYTES > 1) ? $clog2(MAX_COLUMN_BYTES) : 1;

	// The column length register takes every write transaction at once; the user
	// only writes it while the block is idle.
	logic [LEN_W-1:0] column_bytes_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_bytes_q <= COLUMN_BYTES_RESET;
		end else if (cfg.valid) begin
			column_bytes_q <= cfg.column_bytes;
		end
	end

	// The output register is free when it is empty or its result leaves this cycle.
	logic              out_valid_q;
	logic              slot_free;
	logic              res_load;
	res_t              res;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [PIXEL_W-1:0] ram_rdata;

	assign slot_free = !out_valid_q || bus.ready;

	// The sequencer writes each new byte into the store at the fill position and,
	// once a column is complete, walks the store from its first entry.
	ipdbf_seq #(
		.MAX_COLUMN_BYTES(MAX_COLUMN_BYTES)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.column_bytes(column_bytes_q),
		.pix_valid   (pix.valid),
		.pix_pair    (pix.pixel_pair),
		.pix_eob     (pix.end_of_buffer),
		.pix_ready   (pix.ready),
		.slot_free   (slot_free),
		.res_load    (res_load),
		.res         (res),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata)
	);

	ipdbf_ram #(
		.W    (PIXEL_W),
		.DEPTH(MAX_COLUMN_BYTES)
	) u_column_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(pix.pixel_pair),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// The palette lookup maps both nibbles of each byte; direct and replayed bytes both
	// pass through it on their way into the output register.
	logic [BUS_W-1:0] bus_first_q;
	logic [BUS_W-1:0] bus_second_q;
	logic             is_replay_q;
	logic             last_result_q;
	logic             partial_column_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= 1'b1;
		end else if (bus.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			bus_first_q      <= bus_value(res.pair[3:0]);
			bus_second_q     <= bus_value(res.pair[7:4]);
			is_replay_q      <= res.is_replay;
			last_result_q    <= res.last_result;
			partial_column_q <= res.partial_column;
		end
	end

	assign bus.valid          = out_valid_q;
	assign bus.bus_first      = bus_first_q;
	assign bus.bus_second     = bus_second_q;
	assign bus.is_replay      = is_replay_q;
	assign bus.last_result    = last_result_q;
	assign bus.partial_column = partial_column_q;

endmodule

// ===== bench/indexed_pixel_doubling_bus_feeder_tb.sv =====
// Self-checking testbench for the indexed pixel doubling bus feeder.
`timescale 1ns / 100ps

module indexed_pixel_doubling_bus_feeder_tb;
	import ipdbf_pkg::*;

	// The block's store depth. The instance below uses the same default.
	localparam int COLUMN_DEPTH = 60;

	// Each byte on the bus is looked up through this palette, written out apart from
	// the package's table.
	localparam logic [7:0] PALETTE_LEVELS [16] = '{
		8'd0,  8'd9,  8'd18, 8'd27, 8'd33,  8'd40,  8'd51,  8'd58,
		8'd66, 8'd75, 8'd80, 8'd89, 8'd99, 8'd106, 8'd113, 8'd120
	};

	// One bus transaction as it leaves the block.
	typedef struct packed {
		logic [7:0] bus_first;
		logic [7:0] bus_second;
		logic       is_replay;
		logic       last_result;
		logic       partial_column;
	} bus_word_t;

	// A row of the directed table either writes the column length or sends one byte.
	typedef enum logic {
		ROW_PIXEL,
		ROW_LENGTH
	} row_kind_e;

	// When typed is set, the direct result of the byte is the literal in direct
	// instead of the predicted one; any replay results still come from the predictor.
	typedef struct packed {
		row_kind_e  kind;
		logic [7:0] pair;
		logic       eob;
		logic [5:0] length;
		logic       typed;
		bus_word_t  direct;
	} stim_row_t;

	localparam int DIRECTED_COUNT = 21;

	// The directed part walks the reset state, the partial column flag, the length
	// extremes (zero acting as one, values above the depth acting as the depth), a
	// column completing on the last byte of a buffer and a length lowered while a
	// column is half full.
	localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
		'{ROW_PIXEL,  8'h00, 1'b0, 6'd0,  1'b1, '{8'd0,   8'd0,   1'b0, 1'b1, 1'b0}},
		'{ROW_PIXEL,  8'hFF, 1'b1, 6'd0,  1'b1, '{8'd120, 8'd120, 1'b0, 1'b1, 1'b1}},
		'{ROW_LENGTH, 8'h00, 1'b0, 6'd1,  1'b0, '0},
		'{ROW_PIXEL,  8'h10, 1'b0, 6'd0,  1'b1, '{8'd0,   8'd9,   1'b0, 1'b0, 1'b0}},
		'{ROW_LENGTH, 8'h00, 1'b0, 6'd0,  1'b0, '0},
		'{ROW_PIXEL,  8'hF0, 1'b1, 6'd0,  1'b1, '{8'd0,   8'd120, 1'b0, 1'b0, 1'b0}},
		'{ROW_LENGTH, 8'h00, 1'b0, 6'd3,  1'b0, '0},
		'{ROW_PIXEL,  8'h32, 1'b0, 6'd0,  1'b0, '0},
		'{ROW_PIXEL,  8'h54, 1'b0, 6'd0,  1'b0, '0},
		'{ROW_PIXEL,  8'h76, 1'b0, 6'd0,  1'b0, '0},
		'{ROW_LENGTH, 8'h00, 1'b0, 6'd5,  1'b0, '0},
		'{ROW_PIXEL,  8'h98, 1'b0, 6'd0,  1'b0, '0},
		'{ROW_PIXEL,  8'hBA, 1'b0, 6'd0,  1'b0, '0},
		'{ROW_LENGTH, 8'h00, 1'b0, 6'd2,  1'b0, '0},
		'{ROW_PIXEL,  8'hDC, 1'b0, 6'd0,  1'b0, '0},
		'{ROW_LENGTH, 8'h00, 1'b0, 6'd4,  1'b0, '0},
		'{ROW_PIXEL,  8'hFE, 1'b0, 6'd0,  1'b0, '0},
		'{ROW_PIXEL,  8'hEF, 1'b1, 6'd0,  1'b1, '{8'd120, 8'd113, 1'b0, 1'b1, 1'b1}},
		'{ROW_LENGTH, 8'h00, 1'b0, 6'd63, 1'b0, '0},
		'{ROW_PIXEL,  8'hA5, 1'b0, 6'd0,  1'b0, '0},
		'{ROW_PIXEL,  8'h5A, 1'b0, 6'd0,  1'b0, '0}
	};

	// Column lengths of the first random phases; later phases pick their own.
	localparam int PRESET_COUNT = 7;
	localparam logic [5:0] PRESET_LENGTHS [PRESET_COUNT] = '{
		6'd60, 6'd2, 6'd63, 6'd1, 6'd0, 6'd7, 6'd30
	};

	localparam int RANDOM_ITEMS = 340;
	localparam int LONG_HOLD_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n;

	ipdbf_cfg_if cfg_ch ();
	ipdbf_in_if  pix_ch ();
	ipdbf_out_if bus_ch ();

	indexed_pixel_doubling_bus_feeder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.pix    (pix_ch),
		.bus    (bus_ch)
	);

	// The predictor's own copy of the block's state and its one register.
	logic [7:0] held_pairs [COLUMN_DEPTH];
	logic [5:0] held_count;
	logic [5:0] column_setting;

	// Bus transactions that are predicted but have not yet left the block, oldest first.
	bus_word_t pending_bus_words [$];

	int unsigned mismatch_count;

	// When calm is set, neither side inserts idle cycles, which gives stretches of
	// back-to-back traffic. The sender raises hold_request to make the receiver stop
	// taking results for a long stretch while bytes keep coming.
	bit calm;
	bit hold_request;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Safety net in case the block hangs. The slowest correct run is well under a
	// fifth of this.
	initial begin
		#50_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// Mostly no gap or a short one, now and then a long one.
	function automatic int unsigned pick_gap();
		if (calm)
			return 0;
		if ($urandom_range(0, 1) == 0)
			return 0;
		if ($urandom_range(0, 9) < 8)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	// Zero behaves as one, and anything beyond the store depth behaves as the depth.
	function automatic int unsigned usable_length(input logic [5:0] setting);
		if (setting == 6'd0)
			return 1;
		if (setting > COLUMN_DEPTH)
			return COLUMN_DEPTH;
		return 32'(setting);
	endfunction

	function automatic bus_word_t bus_word_of(input logic [7:0] pair, input logic replay,
		input logic last, input logic partial);
		bus_word_t word;
		word.bus_first      = PALETTE_LEVELS[pair[3:0]];
		word.bus_second     = PALETTE_LEVELS[pair[7:4]];
		word.is_replay      = replay;
		word.last_result    = last;
		word.partial_column = partial;
		return word;
	endfunction

	// Works out every bus transaction that one accepted byte causes. The byte itself
	// always goes out first. If it fills the column, everything held is replayed in
	// order and the store empties. Otherwise, an end of buffer drops the held bytes
	// and flags the direct result as belonging to a partial column.
	function automatic void predict_bus_words(input logic [7:0] pair, input logic eob);
		logic [5:0] held;
		if (held_count < COLUMN_DEPTH) begin
			held_pairs[held_count] = pair;
			held_count++;
		end
		if (held_count >= usable_length(column_setting)) begin
			held = held_count;
			pending_bus_words.push_back(bus_word_of(pair, 1'b0, 1'b0, 1'b0));
			for (logic [5:0] i = '0; i < held; i++)
				pending_bus_words.push_back(bus_word_of(held_pairs[i], 1'b1,
					(i + 6'd1 == held), 1'b0));
			held_count = '0;
		end else if (eob) begin
			pending_bus_words.push_back(bus_word_of(pair, 1'b0, 1'b1, 1'b1));
			held_count = '0;
		end else begin
			pending_bus_words.push_back(bus_word_of(pair, 1'b0, 1'b1, 1'b0));
		end
	endfunction

	// Compares one bus transaction with the oldest prediction, field by field.
	function automatic void check_bus_word(input bus_word_t got);
		bus_word_t want;
		if (pending_bus_words.size() == 0) begin
			$error("unexpected bus transaction: bus_first %0d, bus_second %0d",
				got.bus_first, got.bus_second);
			mismatch_count++;
			return;
		end
		want = pending_bus_words.pop_front();
		if (got.bus_first !== want.bus_first) begin
			$error("bus_first: expected %0d, got %0d", want.bus_first, got.bus_first);
			mismatch_count++;
		end
		if (got.bus_second !== want.bus_second) begin
			$error("bus_second: expected %0d, got %0d", want.bus_second, got.bus_second);
			mismatch_count++;
		end
		if (got.is_replay !== want.is_replay) begin
			$error("is_replay: expected %0b, got %0b", want.is_replay, got.is_replay);
			mismatch_count++;
		end
		if (got.last_result !== want.last_result) begin
			$error("last_result: expected %0b, got %0b", want.last_result, got.last_result);
			mismatch_count++;
		end
		if (got.partial_column !== want.partial_column) begin
			$error("partial_column: expected %0b, got %0b", want.partial_column,
				got.partial_column);
			mismatch_count++;
		end
	endfunction

	// Offers one byte, after a random gap, and predicts its results once the
	// transaction has happened. Valid is left high on return, so that a following byte
	// can go out in the very next cycle without valid dropping in between.
	task automatic send_pixel(input logic [7:0] pair, input logic eob, input logic typed,
		input bus_word_t direct);
		int unsigned gap;
		int unsigned direct_slot;
		gap = pick_gap();
		if (gap > 0) begin
			pix_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_ch.valid         <= 1'b1;
		pix_ch.pixel_pair    <= pair;
		pix_ch.end_of_buffer <= eob;
		do @(posedge clk); while (!pix_ch.ready);
		direct_slot = pending_bus_words.size();
		predict_bus_words(pair, eob);
		if (typed)
			pending_bus_words[direct_slot] = direct;
	endtask

	// Stops offering bytes and waits until every predicted transaction has come out.
	// It always waits for a clock edge first, so valid is never lowered and raised
	// again within the same time step.
	task automatic settle_bus();
		pix_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_bus_words.size() != 0);
	endtask

	// The block is idle once nothing is pending, since every byte causes at least one
	// result. The new length then takes effect for the following byte.
	task automatic write_column_length(input logic [5:0] length);
		settle_bus();
		cfg_ch.valid        <= 1'b1;
		cfg_ch.column_bytes <= length;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid   <= 1'b0;
		column_setting = length;
	endtask

	// Receiver: checks each bus transaction and decides ready for the next cycle. A
	// hold request from the sender stops it for a long, counted stretch.
	initial begin
		int unsigned hold_left;
		int unsigned stall_left;
		bus_word_t got;
		hold_left  = 0;
		stall_left = 0;
		bus_ch.ready <= 1'b0;
		@(posedge clk);
		while (arst_n !== 1'b1) @(posedge clk);
		forever begin
			@(posedge clk);
			if (bus_ch.valid && bus_ch.ready) begin
				got = '{bus_ch.bus_first, bus_ch.bus_second, bus_ch.is_replay,
					bus_ch.last_result, bus_ch.partial_column};
				check_bus_word(got);
			end
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left    = LONG_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				bus_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				bus_ch.ready <= 1'b0;
			end else begin
				bus_ch.ready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	// Sender: reset, the directed table, then random phases at several column lengths.
	initial begin
		int unsigned random_items;
		int unsigned phase;
		int unsigned phase_items;
		int unsigned eob_odds;
		logic [5:0] length;

		// Every input of the block is known from the first instant.
		arst_n               <= 1'b0;
		cfg_ch.valid         <= 1'b0;
		cfg_ch.column_bytes  <= '0;
		pix_ch.valid         <= 1'b0;
		pix_ch.pixel_pair    <= '0;
		pix_ch.end_of_buffer <= 1'b0;
		calm           = 1'b0;
		hold_request   = 1'b0;
		mismatch_count = 0;
		held_count     = '0;
		column_setting = COLUMN_BYTES_RESET;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED_ROWS[r]) begin
			if (DIRECTED_ROWS[r].kind == ROW_LENGTH)
				write_column_length(DIRECTED_ROWS[r].length);
			else
				send_pixel(DIRECTED_ROWS[r].pair, DIRECTED_ROWS[r].eob,
					DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].direct);
		end

		// Each phase writes a new length while the block is idle. Whatever bytes are
		// still held carry over, so a shorter length often lands in the middle of a
		// column. Long columns get long phases with rare buffer ends, so that they
		// actually fill and replay; short columns get short phases with frequent ends.
		random_items = 0;
		phase        = 0;
		while (random_items < RANDOM_ITEMS) begin
			if (phase < PRESET_COUNT)
				length = PRESET_LENGTHS[phase];
			else if ($urandom_range(0, 3) != 0)
				length = 6'($urandom_range(0, 8));
			else
				length = 6'($urandom_range(0, 63));
			write_column_length(length);
			calm = (phase % 3 == 2);
			if (usable_length(length) >= 30) begin
				phase_items = 70;
				eob_odds    = 60;
			end else begin
				phase_items = $urandom_range(15, 35);
				eob_odds    = 6;
			end
			for (int n = 0; n < phase_items; n++) begin
				// With two-byte columns almost every byte replays, so stalling the
				// receiver here backs the block up all the way to its input.
				if (phase == 1 && n == 3)
					hold_request = 1'b1;
				// Once, in the third phase, the sender waits for the block to drain completely.
				if (phase == 2 && n == 10)
					settle_bus();
				send_pixel(8'($urandom_range(0, 255)), ($urandom_range(1, eob_odds) == 1),
					1'b0, '0);
				random_items++;
			end
			phase++;
		end

		calm = 1'b0;
		settle_bus();
		// The bench waits on to catch any transaction that should not be there.
		repeat (20) @(posedge clk);
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/ipdbf_pkg.sv
rtl/ipdbf_if.sv
rtl/ipdbf_ram.sv
rtl/ipdbf_seq.sv
rtl/indexed_pixel_doubling_bus_feeder.sv
bench/indexed_pixel_doubling_bus_feeder_tb.sv
